@@ rtl/lsmd_pkg.sv @@
`default_nettype none
package lsmd_pkg;

	typedef enum logic [1:0] {
		PH_SKIP    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// Position within the three-byte message header.
	localparam logic [1:0] HC_SIZE_LO = 2'd0;
	localparam logic [1:0] HC_SIZE_HI = 2'd1;
	localparam logic [1:0] HC_TYPE    = 2'd2;

	localparam logic [7:0] NO_OFFSET     = 8'd255;
	localparam logic [4:0] HDR_LEN_RESET = 5'd16;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  skip_count;
		logic [1:0]  header_count;
		logic [15:0] frame_len;
		logic [7:0]  type_reg;
		logic [15:0] payload_count;
	} dfr_state_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  payload_byte;
		logic        has_byte;
		logic [7:0]  rec_type;
		logic [15:0] payload_index;
		logic        msg_first;
		logic        msg_last;
		logic        aborted;
	} dfr_result_t;

	localparam dfr_state_t STATE_RESET = '{
		phase:         PH_SKIP,
		skip_count:    5'd0,
		header_count:  2'd0,
		frame_len:     16'd0,
		type_reg:      8'd0,
		payload_count: 16'd0
	};

endpackage
`default_nettype wire

@@ rtl/lsmd_step.sv @@
`default_nettype none
module lsmd_step
	import lsmd_pkg::*;
(
	input  wire dfr_state_t  st,
	input  wire [4:0]        hdr_len,
	input  wire [7:0]        data_byte,
	input  wire [7:0]        pos_in_chunk,
	input  wire [7:0]        first_msg_offset,
	output dfr_state_t       st_nxt,
	output dfr_result_t      res
);

	logic        mark;
	logic        last;
	logic        skipping;
	phase_t      ph;

	assign mark = (first_msg_offset != NO_OFFSET) && (pos_in_chunk == first_msg_offset);
	assign skipping = (st.phase == PH_SKIP) && (st.skip_count < hdr_len);
	assign last = ({1'b0, st.payload_count} + 17'd1) >= {1'b0, st.frame_len};

	always_comb begin
		st_nxt = st;
		res = '0;
		ph = st.phase;
		if (skipping) begin
			st_nxt.skip_count = st.skip_count + 5'd1;
		end else begin
			if (ph == PH_SKIP) begin
				ph = PH_HEADER;
				st_nxt.header_count = HC_SIZE_LO;
			end
			// A start mark inside a partial message drops it and restarts
			// framing on this byte.
			if (mark) begin
				if (ph == PH_PAYLOAD) begin
					res.valid         = 1'b1;
					res.rec_type      = st.type_reg;
					res.payload_index = st.payload_count;
					res.msg_first     = (st.payload_count == 16'd0);
					res.msg_last      = 1'b1;
					res.aborted       = 1'b1;
				end else if (st_nxt.header_count != HC_SIZE_LO) begin
					res.valid     = 1'b1;
					res.msg_first = 1'b1;
					res.msg_last  = 1'b1;
					res.aborted   = 1'b1;
				end
				ph = PH_HEADER;
				st_nxt.header_count  = HC_SIZE_LO;
				st_nxt.payload_count = 16'd0;
			end
			if (ph == PH_PAYLOAD) begin
				res.valid         = 1'b1;
				res.payload_byte  = data_byte;
				res.has_byte      = 1'b1;
				res.rec_type      = st.type_reg;
				res.payload_index = st.payload_count;
				res.msg_first     = (st.payload_count == 16'd0);
				res.msg_last      = last;
				if (last) begin
					st_nxt.phase         = PH_HEADER;
					st_nxt.header_count  = HC_SIZE_LO;
					st_nxt.payload_count = 16'd0;
				end else begin
					st_nxt.phase         = PH_PAYLOAD;
					st_nxt.payload_count = st.payload_count + 16'd1;
				end
			end else begin
				st_nxt.phase = PH_HEADER;
				case (st_nxt.header_count)
					HC_SIZE_LO: begin
						st_nxt.frame_len[7:0] = data_byte;
						st_nxt.header_count   = HC_SIZE_HI;
					end
					HC_SIZE_HI: begin
						st_nxt.frame_len[15:8] = data_byte;
						st_nxt.header_count    = HC_TYPE;
					end
					default: begin
						st_nxt.type_reg      = data_byte;
						st_nxt.header_count  = HC_SIZE_LO;
						st_nxt.payload_count = 16'd0;
						if (st.frame_len == 16'd0) begin
							res.valid     = 1'b1;
							res.rec_type  = data_byte;
							res.msg_first = 1'b1;
							res.msg_last  = 1'b1;
						end else begin
							st_nxt.phase = PH_PAYLOAD;
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/log_stream_message_deframer_core.sv @@
`default_nettype none
// Log stream deframer. Bytes arrive one per item, each with its position in
// the transport chunk and the chunk's first-message offset. After reset the
// first file_header_len bytes are skipped once; then every message is a
// little-endian 16-bit size and a type byte followed by the payload, and each
// payload byte leaves as one result item with its type, index and first/last
// flags. A zero-size message yields one empty item, and a message start marked
// while a message is partial yields one abort item before framing restarts
// on the marked byte. The block takes one byte per clock cycle while out_stall
// does not hold the result register; an item is captured in an input register
// and its result is then written to a result register.
// file_header_len should only be written while no items are in flight.
module log_stream_message_deframer_core
	import lsmd_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [4:0]  cfg_wdata,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [7:0]  data_byte,
	input  wire [7:0]  pos_in_chunk,
	input  wire [7:0]  first_msg_offset,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic [7:0] rec_type,
	output logic [15:0] payload_index,
	output logic       msg_first,
	output logic       msg_last,
	output logic       aborted
);

	logic [4:0]  hdr_len_q;
	dfr_state_t  st_q;
	dfr_state_t  st_nxt;
	dfr_result_t res;
	dfr_result_t out_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic [7:0] pos_s1;
	logic [7:0] fmo_s1;
	logic       adv;
	logic       accept;

	// The held item moves on whenever the result register is free or being taken.
	assign adv      = !out_q.valid || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_len_q <= HDR_LEN_RESET;
		end else if (cfg_we) begin
			hdr_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			pos_s1  <= pos_in_chunk;
			fmo_s1  <= first_msg_offset;
		end
	end

	lsmd_step u_step (
		.st               (st_q),
		.hdr_len          (hdr_len_q),
		.data_byte        (data_s1),
		.pos_in_chunk     (pos_s1),
		.first_msg_offset (fmo_s1),
		.st_nxt           (st_nxt),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (valid_s1 && adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (adv) begin
			out_q       <= res;
			out_q.valid <= valid_s1 && res.valid;
		end
	end

	assign out_valid     = out_q.valid;
	assign payload_byte  = out_q.payload_byte;
	assign has_byte      = out_q.has_byte;
	assign rec_type      = out_q.rec_type;
	assign payload_index = out_q.payload_index;
	assign msg_first     = out_q.msg_first;
	assign msg_last      = out_q.msg_last;
	assign aborted       = out_q.aborted;

	a_abort_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && aborted |-> msg_last && !has_byte && (payload_byte == 8'd0))
		else $error("abort item with a payload byte or without last flag");

	a_payload_size: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_PAYLOAD |-> st_q.frame_len != 16'd0)
		else $error("payload phase entered with a zero message size");

	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_SKIP |-> (st_q.header_count == HC_SIZE_LO)
			&& (st_q.payload_count == 16'd0))
		else $error("framing counters moved during file header skip");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without an item in the input register");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import lsmd_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic [7:0] pos;
		logic [7:0] fmo;
	} stream_item_t;

	typedef struct {
		logic [7:0]  payload_byte;
		logic        has_byte;
		logic [7:0]  rec_type;
		logic [15:0] payload_index;
		logic        msg_first;
		logic        msg_last;
		logic        aborted;
	} frame_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = 5'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic [7:0]  pos_in_chunk = 8'd0;
	logic [7:0]  first_msg_offset = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic        has_byte;
	logic [7:0]  rec_type;
	logic [15:0] payload_index;
	logic        msg_first;
	logic        msg_last;
	logic        aborted;

	log_stream_message_deframer_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.pos_in_chunk     (pos_in_chunk),
		.first_msg_offset (first_msg_offset),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.payload_byte     (payload_byte),
		.has_byte         (has_byte),
		.rec_type         (rec_type),
		.payload_index    (payload_index),
		.msg_first        (msg_first),
		.msg_last         (msg_last),
		.aborted          (aborted)
	);

	stream_item_t byte_q[$];
	frame_t       frames_due_q[$];
	frame_t       want_frame;
	logic         in_fire = 1'b0;
	logic         calm = 1'b0;
	int           in_gap = 0;
	int           out_gap = 0;
	int           err_cnt = 0;
	int           n_items = 0;
	int           n_frames = 0;
	int           n_aborts = 0;
	int           n_empty = 0;

	// Shadow deframer state.
	phase_t       ph = PH_SKIP;
	logic [4:0]   skip_n = 5'd0;
	logic [1:0]   hdr_n = HC_SIZE_LO;
	logic [15:0]  size_r = 16'd0;
	logic [7:0]   type_r = 8'd0;
	logic [15:0]  pay_n = 16'd0;
	logic [4:0]   hdr_len_m = HDR_LEN_RESET;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic frame_t mk_frame(input logic [7:0] b, input logic has,
			input logic [7:0] typ, input logic [15:0] idx, input logic first,
			input logic last, input logic ab);
		frame_t f;
		f.payload_byte = b;
		f.has_byte = has;
		f.rec_type = typ;
		f.payload_index = idx;
		f.msg_first = first;
		f.msg_last = last;
		f.aborted = ab;
		return f;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic [7:0] pos,
			input logic [7:0] fmo);
		logic mark;
		logic last;
		mark = (fmo != NO_OFFSET) && (pos == fmo);
		if (ph == PH_SKIP) begin
			if (skip_n < hdr_len_m) begin
				skip_n = skip_n + 5'd1;
				return;
			end
			ph = PH_HEADER;
			hdr_n = HC_SIZE_LO;
		end
		// A marked start drops whatever message is only partly in.
		if (mark) begin
			if (ph == PH_PAYLOAD)
				frames_due_q.push_back(mk_frame(8'd0, 1'b0, type_r, pay_n,
					pay_n == 16'd0, 1'b1, 1'b1));
			else if (hdr_n != HC_SIZE_LO)
				frames_due_q.push_back(mk_frame(8'd0, 1'b0, 8'd0, 16'd0,
					1'b1, 1'b1, 1'b1));
			ph = PH_HEADER;
			hdr_n = HC_SIZE_LO;
			pay_n = 16'd0;
		end
		if (ph == PH_PAYLOAD) begin
			last = ({1'b0, pay_n} + 17'd1) >= {1'b0, size_r};
			frames_due_q.push_back(mk_frame(b, 1'b1, type_r, pay_n,
				pay_n == 16'd0, last, 1'b0));
			if (last) begin
				ph = PH_HEADER;
				hdr_n = HC_SIZE_LO;
				pay_n = 16'd0;
			end else begin
				pay_n = pay_n + 16'd1;
			end
			return;
		end
		ph = PH_HEADER;
		case (hdr_n)
			HC_SIZE_LO: begin
				size_r[7:0] = b;
				hdr_n = HC_SIZE_HI;
			end
			HC_SIZE_HI: begin
				size_r[15:8] = b;
				hdr_n = HC_TYPE;
			end
			default: begin
				type_r = b;
				hdr_n = HC_SIZE_LO;
				pay_n = 16'd0;
				if (size_r == 16'd0)
					frames_due_q.push_back(mk_frame(8'd0, 1'b0, type_r, 16'd0,
						1'b1, 1'b1, 1'b0));
				else
					ph = PH_PAYLOAD;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Monitor: checks result items and predicts from accepted input items.
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_we)
				hdr_len_m = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (frames_due_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result item arrived with none expected", $time);
				end else begin
					want_frame = frames_due_q.pop_front();
					n_frames++;
					if (want_frame.aborted)
						n_aborts++;
					else if (!want_frame.has_byte)
						n_empty++;
					check_field("payload_byte", 16'(want_frame.payload_byte),
						16'(payload_byte));
					check_field("has_byte", 16'(want_frame.has_byte), 16'(has_byte));
					check_field("rec_type", 16'(want_frame.rec_type), 16'(rec_type));
					check_field("payload_index", want_frame.payload_index, payload_index);
					check_field("msg_first", 16'(want_frame.msg_first), 16'(msg_first));
					check_field("msg_last", 16'(want_frame.msg_last), 16'(msg_last));
					check_field("aborted", 16'(want_frame.aborted), 16'(aborted));
				end
			end
			if (in_valid && !in_stall) begin
				n_items++;
				deframe_byte(data_byte, pos_in_chunk, first_msg_offset);
			end
		end
	end

	// Driver: presents queued items, holding each until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire)
				void'(byte_q.pop_front());
			if (!in_valid || in_fire) begin
				if (in_gap != 0) begin
					in_gap = in_gap - 1;
					in_valid <= 1'b0;
				end else if (byte_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					data_byte <= byte_q[0].data;
					pos_in_chunk <= byte_q[0].pos;
					first_msg_offset <= byte_q[0].fmo;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_stall <= 1'b0;
		end else if (out_gap != 0) begin
			out_gap = out_gap - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic put_byte(input logic [7:0] b, input bit mark);
		stream_item_t it;
		it.data = b;
		it.pos = 8'($urandom_range(0, 254));
		if (mark)
			it.fmo = it.pos;
		else if ($urandom_range(0, 3) == 0) begin
			it.pos = NO_OFFSET;
			it.fmo = NO_OFFSET;
		end else if ($urandom_range(0, 1) == 0)
			it.fmo = NO_OFFSET;
		else
			it.fmo = it.pos + 8'd1;
		byte_q.push_back(it);
	endtask

	// Builds a byte stream of messages, mostly well formed, then cuts it into
	// chunks whose first-message offset mostly points at the first start inside.
	task automatic gen_stream(input int n_bytes);
		logic [7:0]   strm[$];
		bit           starts[$];
		stream_item_t it;
		int           kind;
		int           size;
		int           keep;
		int           hdr_keep;
		int           i;
		int           j;
		int           len;
		int           base;
		int           first;
		logic [7:0]   fmo;
		while (strm.size() < n_bytes) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				repeat ($urandom_range(1, 4)) begin
					strm.push_back(8'($urandom));
					starts.push_back(1'b0);
				end
			end else begin
				if (kind < 22)
					size = $urandom_range(0, 65535);
				else if ($urandom_range(0, 99) < 85)
					size = $urandom_range(0, 8);
				else
					size = $urandom_range(9, 60);
				keep = size;
				hdr_keep = 3;
				if (kind < 15)
					hdr_keep = $urandom_range(1, 2);
				else if (kind < 22)
					keep = $urandom_range(0, size < 6 ? size : 6);
				strm.push_back(8'(size));
				starts.push_back(1'b1);
				if (hdr_keep > 1) begin
					strm.push_back(8'(size >> 8));
					starts.push_back(1'b0);
				end
				if (hdr_keep > 2) begin
					strm.push_back(8'($urandom));
					starts.push_back(1'b0);
					repeat (keep) begin
						strm.push_back(8'($urandom));
						starts.push_back(1'b0);
					end
				end
			end
		end
		i = 0;
		while (i < strm.size()) begin
			len = $urandom_range(1, 24);
			if (len > strm.size() - i)
				len = strm.size() - i;
			base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255 - len) : 0;
			first = -1;
			for (j = 0; j < len; j++)
				if (first < 0 && starts[i + j])
					first = j;
			fmo = (first < 0) ? NO_OFFSET : 8'(base + first);
			if ($urandom_range(0, 15) == 0)
				fmo = 8'($urandom);
			for (j = 0; j < len; j++) begin
				it.data = strm[i + j];
				it.pos = 8'(base + j);
				it.fmo = fmo;
				byte_q.push_back(it);
			end
			i += len;
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (byte_q.size() != 0 || in_valid || frames_due_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_hdr_len(input logic [4:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// File header: a marked byte in it is simply skipped, then the length
		// is lowered below the count already skipped.
		write_hdr_len(5'd31);
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b0);
		byte_q.push_back('{data: 8'h5A, pos: NO_OFFSET, fmo: NO_OFFSET});
		put_byte(8'h12, 1'b1);
		put_byte(8'h34, 1'b0);
		wait_drained();
		write_hdr_len(5'd0);

		// Empty message marked at a boundary, then a two-byte message.
		put_byte(8'h00, 1'b1);
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h02, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		// Marks inside a header and inside a payload.
		put_byte(8'h05, 1'b0);
		put_byte(8'h03, 1'b1);
		put_byte(8'h00, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_byte(8'h11, 1'b0);
		put_byte(8'h01, 1'b1);
		put_byte(8'h00, 1'b0);
		put_byte(8'h7E, 1'b0);
		put_byte(8'hC3, 1'b0);
		// Mark right after a complete header, before any payload byte.
		put_byte(8'h04, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h22, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'h01, 1'b0);
		put_byte(8'h5A, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'h07, 1'b1);
		put_byte(8'h40, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'h00, 1'b0);
		put_byte(8'h3C, 1'b0);
		wait_drained();

		write_hdr_len(5'd16);
		gen_stream(150);
		wait_drained();
		write_hdr_len(5'($urandom_range(0, 31)));
		gen_stream(150);
		wait_drained();
		write_hdr_len(5'd31);
		calm = 1'b1;
		gen_stream(120);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Accepted %0d bytes; checked %0d result items, %0d aborts, %0d empty.",
			n_items, n_frames, n_aborts, n_empty);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
